/* hw/rtl/rle565_pkg.sv */
// ----------------------------------------------------------------------------
// RLE565 package
// Shared widths, payload structs, register map and parser phases of the
// run-length RGB565 line decoder.
// ----------------------------------------------------------------------------
package rle565_pkg;

  // Width of an x coordinate on the display line.
  localparam int X_BITS = 12;
  // Signed width that holds cursor and tile end positions with headroom.
  localparam int CW     = X_BITS + 3;
  // APB address width: five word-aligned registers.
  localparam int ADDR_W = 5;

  // Register indexes (word address bits of paddr).
  localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
  localparam logic [2:0] REG_TILE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OFFSET      = 3'd3;
  localparam logic [2:0] REG_DRAW_ENABLE = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LOW,
    PH_HIGH,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_start;
  } data_t;

  typedef struct packed {
    logic [X_BITS-1:0] span_x;
    logic [7:0]        span_len;
    logic [15:0]       pixel_value;
    logic              tile_done;
    logic              line_done;
  } span_t;

  typedef struct packed {
    logic [X_BITS-1:0] clip_left;
    logic [X_BITS-1:0] clip_right;
    logic [X_BITS:0]   tile_width;
    logic [X_BITS-1:0] offset_in_tile;
    logic              draw_enable;
  } cfg_t;

endpackage

/* hw/rtl/rle565_cfg.sv */
// ----------------------------------------------------------------------------
// RLE565 configuration registers
// APB register file holding clip window, tile width, tile offset and draw
// enable for the line decoder.
// ----------------------------------------------------------------------------
module rle565_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rle565_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rle565_pkg::cfg_t              cfg
);
  import rle565_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left      <= '0;
      cfg.clip_right     <= '1;
      cfg.tile_width     <= (X_BITS+1)'(1);
      cfg.offset_in_tile <= '0;
      cfg.draw_enable    <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLIP_LEFT:   cfg.clip_left      <= pwdata[X_BITS-1:0];
        REG_CLIP_RIGHT:  cfg.clip_right     <= pwdata[X_BITS-1:0];
        REG_TILE_WIDTH:  cfg.tile_width     <= pwdata[X_BITS:0];
        REG_OFFSET:      cfg.offset_in_tile <= pwdata[X_BITS-1:0];
        REG_DRAW_ENABLE: cfg.draw_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CLIP_LEFT:   prdata = 32'(cfg.clip_left);
      REG_CLIP_RIGHT:  prdata = 32'(cfg.clip_right);
      REG_TILE_WIDTH:  prdata = 32'(cfg.tile_width);
      REG_OFFSET:      prdata = 32'(cfg.offset_in_tile);
      REG_DRAW_ENABLE: prdata = 32'(cfg.draw_enable);
      default:         prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/rle565_tiled_line_decoder_unit.sv */
// ----------------------------------------------------------------------------
// RLE565 tiled line decoder
// Decodes a run-length coded RGB565 pixelmap row into clipped spans, tiling
// the row across a display line.
// ----------------------------------------------------------------------------
// Usage:
// The compressed row enters one byte per request on the data channel
// (data_valid / data_stall / data). The first byte of a line carries
// line_start. Every completed pixel (a whole repeat run, or one literal
// pixel) leaves as one span request on the span channel (span_valid /
// span_stall / span). A span with tile_done and no line_done asks the feeder
// to send the row bytes again for the next tile; line_done ends the line,
// and further bytes without line_start are swallowed without a result.
// A byte is taken every clock while data_stall is low. It waits in the
// input register and is then decoded into the span register, so a span
// is registered from its last byte. Header and low bytes give no span.
// When the span receiver stalls, the pending span holds and one more byte
// can still wait in the input register; only then is data_stall raised.
// Reset empties both registers, puts the parser in front of a header byte
// and loads the register defaults: full clip window, tile width one, no
// offset, drawing enabled. The user must write registers through the APB
// port only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rle565_tiled_line_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rle565_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Compressed byte stream
  input  logic                          data_valid,
  output logic                          data_stall,
  input  rle565_pkg::data_t             data,
  // Decoded spans
  output logic                          span_valid,
  input  logic                          span_stall,
  output rle565_pkg::span_t             span
);
  import rle565_pkg::*;

  cfg_t cfg;

  rle565_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic  in_valid;
  data_t in_item;

  // Parser and tiling state.
  phase_t                phase, phase_next;
  logic [7:0]            run_rem, run_rem_next;
  logic                  run_rep, run_rep_next;
  logic [7:0]            low_hold, low_hold_next;
  logic signed [CW-1:0]  cursor, cursor_next;
  logic signed [CW-1:0]  tile_end, tile_end_next;
  logic                  skip, skip_next;

  // Handshake control.
  logic out_free;
  logic go;
  logic accept;

  assign out_free   = !span_valid || !span_stall;
  assign go         = in_valid && out_free;
  assign data_stall = in_valid && !out_free;
  assign accept     = data_valid && !data_stall;

  // Shared datapath terms.
  logic [7:0]           byte_in;
  logic                 ls;
  logic signed [CW-1:0] eff_w;
  logic signed [CW-1:0] clip_l, clip_r;
  logic                 ls_skip;
  logic signed [CW-1:0] ls_cursor;
  logic [7:0]           count;
  logic signed [CW-1:0] count_s;
  logic signed [CW-1:0] span_hi, lo_c, hi_c;
  logic signed [CW-1:0] cursor_adv;
  logic [7:0]           rem_after;
  logic                 tile_hit;
  logic                 line_end;
  logic                 emit;
  span_t                span_next;

  assign byte_in = in_item.data_byte;
  assign ls      = in_item.line_start;
  // A tile width of zero behaves as one.
  assign eff_w   = (cfg.tile_width == '0) ? CW'(1)
                                          : $signed(CW'(cfg.tile_width));
  assign clip_l  = $signed(CW'(cfg.clip_left));
  assign clip_r  = $signed(CW'(cfg.clip_right));

  // Line start: either lay the row down from the left clip edge minus the
  // tile offset, or run through it once in skip mode.
  assign ls_skip   = !(cfg.draw_enable && (cfg.clip_left <= cfg.clip_right));
  assign ls_cursor = ls_skip ? '0
                             : clip_l - $signed(CW'(cfg.offset_in_tile));

  // A repeat run covers its whole length at once; a literal covers one pixel.
  assign count      = run_rep ? run_rem : 8'd1;
  assign count_s    = $signed(CW'(count));
  assign cursor_adv = cursor + count_s;
  assign span_hi    = cursor_adv - CW'(1);
  assign lo_c       = (cursor < clip_l) ? clip_l : cursor;
  assign hi_c       = (span_hi > clip_r) ? clip_r : span_hi;
  assign rem_after  = run_rep ? 8'd0 : ((run_rem != 8'd0) ? run_rem - 8'd1 : 8'd0);
  // The tile end is only checked once a run is finished.
  assign tile_hit   = (rem_after == 8'd0) && (cursor_adv >= tile_end);
  assign line_end   = tile_hit && (skip || (tile_end > clip_r));
  assign emit       = go && !ls && (phase == PH_HIGH);

  // Parser phase.
  always_comb begin
    phase_next = phase;
    if (go) begin
      if (ls) begin
        phase_next = PH_LOW;
      end else begin
        case (phase)
          PH_HEADER: phase_next = PH_LOW;
          PH_LOW:    phase_next = PH_HIGH;
          PH_HIGH: begin
            if (rem_after != 8'd0) begin
              phase_next = PH_LOW;
            end else if (line_end) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_IDLE:   phase_next = PH_IDLE;
          default:   phase_next = PH_HEADER;
        endcase
      end
    end
  end

  // Run, pixel and position bookkeeping, and the span that a pixel yields.
  always_comb begin
    run_rem_next  = run_rem;
    run_rep_next  = run_rep;
    low_hold_next = low_hold;
    cursor_next   = cursor;
    tile_end_next = tile_end;
    skip_next     = skip;

    span_next.pixel_value = {byte_in, low_hold};
    span_next.tile_done   = tile_hit;
    span_next.line_done   = line_end;
    if (skip || (hi_c < lo_c)) begin
      span_next.span_x   = '0;
      span_next.span_len = '0;
    end else begin
      span_next.span_x   = lo_c[X_BITS-1:0];
      span_next.span_len = 8'(hi_c - lo_c + CW'(1));
    end

    if (go) begin
      if (ls) begin
        // The line start byte is itself a header.
        skip_next     = ls_skip;
        cursor_next   = ls_cursor;
        tile_end_next = ls_cursor + eff_w;
        low_hold_next = '0;
        run_rep_next  = byte_in[7];
        run_rem_next  = {1'b0, byte_in[6:0]} + 8'd1;
      end else begin
        case (phase)
          PH_HEADER: begin
            run_rep_next = byte_in[7];
            run_rem_next = {1'b0, byte_in[6:0]} + 8'd1;
          end
          PH_LOW: begin
            low_hold_next = byte_in;
          end
          PH_HIGH: begin
            run_rem_next = rem_after;
            cursor_next  = cursor_adv;
            if (tile_hit && !line_end) begin
              cursor_next   = tile_end;
              tile_end_next = tile_end + eff_w;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      span_valid <= 1'b0;
      phase      <= PH_HEADER;
      run_rem    <= '0;
      run_rep    <= 1'b0;
      low_hold   <= '0;
      cursor     <= '0;
      tile_end   <= '0;
      skip       <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (go) begin
        in_valid <= 1'b0;
      end
      if (emit) begin
        span_valid <= 1'b1;
      end else if (!span_stall) begin
        span_valid <= 1'b0;
      end
      phase    <= phase_next;
      run_rem  <= run_rem_next;
      run_rep  <= run_rep_next;
      low_hold <= low_hold_next;
      cursor   <= cursor_next;
      tile_end <= tile_end_next;
      skip     <= skip_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= data;
    end
    if (emit) begin
      span <= span_next;
    end
  end

endmodule

/* hw/rtl/rle565_chk.sv */
// ----------------------------------------------------------------------------
// RLE565 port checker
// Assertions on the span channel of the line decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rle565_chk (
  input logic              clk,
  input logic              rst,
  input logic              span_valid,
  input logic              span_stall,
  input rle565_pkg::span_t span
);
  import rle565_pkg::*;

  // Reset leaves no span pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !span_valid)
    else $error("span pending right after reset");

  // A stalled span stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && span_stall |=> span_valid && $stable(span))
    else $error("stalled span changed");

  // An empty span carries x zero.
  a_empty_x: assert property (@(posedge clk) disable iff (rst)
    span_valid && (span.span_len == 8'd0) |-> (span.span_x == '0))
    else $error("empty span with nonzero x");

  // A span never covers more than one full repeat run.
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span.span_len <= 8'd128))
    else $error("span longer than a run");

  // The end of the line is always the end of a tile.
  a_line_tile: assert property (@(posedge clk) disable iff (rst)
    span_valid && span.line_done |-> span.tile_done)
    else $error("line done without tile done");

endmodule

bind rle565_tiled_line_decoder_unit rle565_chk u_rle565_chk (
  .clk        (clk),
  .rst        (rst),
  .span_valid (span_valid),
  .span_stall (span_stall),
  .span       (span)
);
